### design/sipq_pkg.sv
// shared types and constants of the sorted-insert priority queue
package sipq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam int unsigned TAG_W   = 16;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned OCC_W   = 5;

  typedef enum logic [1:0] {
    STATUS_ADDED   = 2'd0,
    STATUS_REMOVED = 2'd1,
    STATUS_EMPTY   = 2'd2,
    STATUS_FULL    = 2'd3
  } status_e;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  // year, month, day in that order so the packed date compares as the key
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } entry_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t data;
  } cmd_t;

  function automatic logic [YEAR_W+MONTH_W+DAY_W-1:0] date_key(input entry_t e);
    return {e.year, e.month, e.day};
  endfunction

endpackage

### design/sipq_cell.sv
// one slot of the sorted shift row: holds an entry and moves it left or right
module sipq_cell
  import sipq_pkg::*;
(
  input  logic   clk_i,
  input  cmd_t   cmd_i,
  input  logic   valid_i,
  input  entry_t left_entry_i,
  input  logic   left_gt_i,
  input  entry_t right_entry_i,
  output entry_t entry_o,
  output logic   gt_o
);

  entry_t entry_q, entry_d;

  // a held entry later than the new one must move one slot towards the tail
  assign gt_o = valid_i && (date_key(entry_q) > date_key(cmd_i.data));

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.push) begin
      if (left_gt_i) begin
        entry_d = left_entry_i;
      end else if (!valid_i || gt_o) begin
        entry_d = cmd_i.data;
      end
    end else if (cmd_i.pop) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

### design/sorted_insert_priority_queue_unit.sv
// top level of the sorted-insert priority queue: cell row, fill count and result word
//
//  channel  | signals                                    | handshake
//  ---------+--------------------------------------------+-----------------------
//  command  | operation_i task_tag_i due_*_i             | start, busy
//  result   | status_o out_*_o occupancy_o               | done_o, one cycle
//
// one word per cycle: every cell compares its date with the pushed one in
// parallel, so the whole row shifts or inserts together
// the result appears on the cycle after the command is taken
// busy stays low; the result has no back-pressure
// reset clears the fill count and the result strobe; entries need no clearing
module sorted_insert_priority_queue_unit
  import sipq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               operation_i,
  input  logic [TAG_W-1:0]   task_tag_i,
  input  logic [DAY_W-1:0]   due_day_i,
  input  logic [MONTH_W-1:0] due_month_i,
  input  logic [YEAR_W-1:0]  due_year_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [TAG_W-1:0]   out_tag_o,
  output logic [DAY_W-1:0]   out_day_o,
  output logic [MONTH_W-1:0] out_month_o,
  output logic [YEAR_W-1:0]  out_year_o,
  output logic [OCC_W-1:0]   occupancy_o
);

  logic accept;
  logic full, empty;
  cmd_t cmd;

  logic [CNT_W-1:0] count_q, count_d;
  logic             done_q;
  status_e          status_q, status_d;
  entry_t           res_q, res_d;

  entry_t cell_entry [DEPTH];
  logic   cell_gt    [DEPTH];
  logic   cell_valid [DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == CNT_W'(DEPTH));
  assign empty  = (count_q == '0);

  always_comb begin
    cmd.data.tag   = task_tag_i;
    cmd.data.year  = due_year_i;
    cmd.data.month = due_month_i;
    cmd.data.day   = due_day_i;
    cmd.push = accept && (operation_i == OP_PUSH) && !full;
    cmd.pop  = accept && (operation_i == OP_POP) && !empty;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_entry, right_entry;
    logic   left_gt;

    assign cell_valid[i] = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_entry = '0;
      assign left_gt    = 1'b0;
    end else begin : g_body
      assign left_entry = cell_entry[i-1];
      assign left_gt    = cell_gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    sipq_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .valid_i       (cell_valid[i]),
      .left_entry_i  (left_entry),
      .left_gt_i     (left_gt),
      .right_entry_i (right_entry),
      .entry_o       (cell_entry[i]),
      .gt_o          (cell_gt[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = status_q;
    res_d    = '0;
    if (accept) begin
      if (operation_i == OP_PUSH) begin
        if (full) begin
          status_d = STATUS_FULL;
        end else begin
          status_d = STATUS_ADDED;
          count_d  = count_q + CNT_W'(1);
        end
      end else begin
        if (empty) begin
          status_d = STATUS_EMPTY;
        end else begin
          status_d = STATUS_REMOVED;
          res_d    = cell_entry[0];
          count_d  = count_q - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      res_q    <= res_d;
    end
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign out_tag_o   = res_q.tag;
  assign out_day_o   = res_q.day;
  assign out_month_o = res_q.month;
  assign out_year_o  = res_q.year;
  assign occupancy_o = OCC_W'(count_q);

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("no result after an accepted command");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && operation_i == OP_PUSH && !full) |=>
      (count_q == $past(count_q) + CNT_W'(1)) && (status_o == STATUS_ADDED))
    else $error("push did not grow the queue");

  a_full_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && operation_i == OP_PUSH && full) |=>
      $stable(count_q) && (status_o == STATUS_FULL) && (out_tag_o == '0))
    else $error("push into a full queue changed state");

endmodule

### verif/testbench.sv
// self-checking bench for the sorted-insert priority queue: directed table, then random words
module testbench;
  import sipq_pkg::*;

  typedef struct packed {
    status_e            status;
    entry_t             out;
    logic [OCC_W-1:0]   occ;
  } queue_result_t;

  typedef struct packed {
    op_e           op;
    entry_t        data;
    logic          pin;
    queue_result_t want;
  } step_t;

  localparam int unsigned RANDOM_WORDS = 1700;
  localparam int unsigned GAP_PCT      = 22;

  // entry_t fields run tag, year, month, day
  localparam step_t STEPS [24] = '{
    '{OP_POP,  '0,                                      1'b1, '{STATUS_EMPTY, '0, 5'd0}},
    '{OP_PUSH, '{16'hFFFF, 14'd9999, 4'd12, 5'd31},     1'b1, '{STATUS_ADDED, '0, 5'd1}},
    '{OP_PUSH, '{16'h0000, 14'd0,    4'd1,  5'd1},      1'b1, '{STATUS_ADDED, '0, 5'd2}},
    '{OP_POP,  '0,                                      1'b1,
      '{STATUS_REMOVED, '{16'h0000, 14'd0, 4'd1, 5'd1}, 5'd1}},
    // three words on one date: they must leave in arrival order
    '{OP_PUSH, '{16'h1111, 14'd2000, 4'd6,  5'd15},     1'b0, '0},
    '{OP_PUSH, '{16'h2222, 14'd2000, 4'd6,  5'd15},     1'b0, '0},
    '{OP_PUSH, '{16'h3333, 14'd2000, 4'd6,  5'd15},     1'b0, '0},
    // date fields outside their usual ranges
    '{OP_PUSH, '{16'hAAAA, 14'd0,     4'd0,  5'd0},     1'b0, '0},
    '{OP_PUSH, '{16'h5555, 14'd16383, 4'd15, 5'd31},    1'b0, '0},
    '{OP_PUSH, '{16'h0F0F, 14'd5000,  4'd13, 5'd7},     1'b0, '0},
    '{OP_PUSH, '{16'h0101, 14'd2001,  4'd3,  5'd9},     1'b0, '0},
    '{OP_PUSH, '{16'h0202, 14'd2009,  4'd1,  5'd1},     1'b0, '0},
    '{OP_PUSH, '{16'h0303, 14'd2004,  4'd11, 5'd30},    1'b0, '0},
    '{OP_PUSH, '{16'h0404, 14'd2001,  4'd3,  5'd8},     1'b0, '0},
    '{OP_PUSH, '{16'h0505, 14'd2006,  4'd7,  5'd4},     1'b0, '0},
    '{OP_PUSH, '{16'h0606, 14'd2002,  4'd2,  5'd28},    1'b0, '0},
    '{OP_PUSH, '{16'h0707, 14'd2008,  4'd12, 5'd1},     1'b0, '0},
    '{OP_PUSH, '{16'h0808, 14'd2003,  4'd5,  5'd16},    1'b0, '0},
    '{OP_PUSH, '{16'h0909, 14'd2005,  4'd9,  5'd2},     1'b0, '0},
    '{OP_PUSH, '{16'hBEEF, 14'd1,     4'd1,  5'd1},     1'b1, '{STATUS_FULL, '0, 5'd16}},
    '{OP_POP,  '0,                                      1'b0, '0},
    '{OP_POP,  '0,                                      1'b0, '0},
    '{OP_POP,  '0,                                      1'b0, '0},
    '{OP_POP,  '0,                                      1'b0, '0}
  };

  logic               clk;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               operation_i;
  logic [TAG_W-1:0]   task_tag_i;
  logic [DAY_W-1:0]   due_day_i;
  logic [MONTH_W-1:0] due_month_i;
  logic [YEAR_W-1:0]  due_year_i;
  logic               done_o;
  logic [1:0]         status_o;
  logic [TAG_W-1:0]   out_tag_o;
  logic [DAY_W-1:0]   out_day_o;
  logic [MONTH_W-1:0] out_month_o;
  logic [YEAR_W-1:0]  out_year_o;
  logic [OCC_W-1:0]   occupancy_o;

  entry_t        shadow_queue[$];
  queue_result_t pending_results[$];
  queue_result_t pinned_result;
  logic          pinned_valid;
  bit            gaps_on;
  int unsigned   mismatches;

  sorted_insert_priority_queue_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .operation_i (operation_i),
    .task_tag_i  (task_tag_i),
    .due_day_i   (due_day_i),
    .due_month_i (due_month_i),
    .due_year_i  (due_year_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .out_tag_o   (out_tag_o),
    .out_day_o   (out_day_o),
    .out_month_o (out_month_o),
    .out_year_o  (out_year_o),
    .occupancy_o (occupancy_o)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic note_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
    end
  endtask

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      note_mismatch(what, want, got);
    end
  endtask

  // shadow copy of the queue: sorted insert, ties behind older words
  task automatic queue_op_predict(input op_e op, input entry_t word,
                                  output queue_result_t res);
    logic [YEAR_W+MONTH_W+DAY_W-1:0] new_key;
    int                              pos;
    res = '0;
    if (op == OP_PUSH) begin
      if (shadow_queue.size() >= DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        new_key = {word.year, word.month, word.day};
        pos = shadow_queue.size();
        for (int i = 0; i < shadow_queue.size(); i++) begin
          if ({shadow_queue[i].year, shadow_queue[i].month, shadow_queue[i].day} > new_key)
          begin
            pos = i;
            break;
          end
        end
        shadow_queue.insert(pos, word);
        res.status = STATUS_ADDED;
      end
    end else begin
      if (shadow_queue.size() == 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        res.out = shadow_queue.pop_front();
        res.status = STATUS_REMOVED;
      end
    end
    res.occ = OCC_W'(shadow_queue.size());
  endtask

  always @(posedge clk) begin
    queue_result_t want;
    queue_result_t predicted;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_results.size() == 0) begin
          note_mismatch("unexpected result word, status", 0, status_o);
        end else begin
          want = pending_results.pop_front();
          check_field("status", want.status, status_o);
          check_field("out_tag", want.out.tag, out_tag_o);
          check_field("out_day", want.out.day, out_day_o);
          check_field("out_month", want.out.month, out_month_o);
          check_field("out_year", want.out.year, out_year_o);
          check_field("occupancy", want.occ, occupancy_o);
        end
      end
      if (start && !busy) begin
        queue_op_predict(op_e'(operation_i),
                         '{tag: task_tag_i, year: due_year_i, month: due_month_i,
                           day: due_day_i}, predicted);
        pending_results.push_back(pinned_valid ? pinned_result : predicted);
      end
    end
  end

  task automatic issue(input op_e op, input entry_t word, input logic pin,
                       input queue_result_t pin_res);
    while (gaps_on && $urandom_range(0, 99) < GAP_PCT) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start         <= 1'b1;
    operation_i   <= op;
    task_tag_i    <= word.tag;
    due_day_i     <= word.day;
    due_month_i   <= word.month;
    due_year_i    <= word.year;
    pinned_valid  <= pin;
    pinned_result <= pin_res;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  initial begin
    int unsigned push_pct;
    int unsigned mode;
    op_e         op;
    entry_t      word;

    clk           = 1'b0;
    rst_ni        = 1'b0;
    start         = 1'b0;
    operation_i   = OP_PUSH;
    task_tag_i    = '0;
    due_day_i     = '0;
    due_month_i   = '0;
    due_year_i    = '0;
    pinned_valid  = 1'b0;
    pinned_result = '0;
    gaps_on       = 1'b1;
    mismatches    = 0;
    push_pct      = 50;

    repeat (4) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    foreach (STEPS[i]) begin
      issue(STEPS[i].op, STEPS[i].data, STEPS[i].pin, STEPS[i].want);
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      gaps_on = !(n >= 500 && n < 850);
      // change the push/pop mix now and then so the fill level swings end to end
      if (n % 100 == 0) begin
        case ($urandom_range(0, 3))
          0: push_pct = 15;
          1: push_pct = 50;
          2: push_pct = 85;
          default: push_pct = 97;
        endcase
      end
      op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
      word.tag = TAG_W'($urandom);
      mode = $urandom_range(0, 9);
      if (mode < 6) begin
        // narrow pool of dates, lots of ties
        word.year  = YEAR_W'(2020 + $urandom_range(0, 3));
        word.month = MONTH_W'($urandom_range(1, 3));
        word.day   = DAY_W'($urandom_range(1, 4));
      end else if (mode < 9) begin
        word.year  = YEAR_W'($urandom_range(0, 9999));
        word.month = MONTH_W'($urandom_range(1, 12));
        word.day   = DAY_W'($urandom_range(1, 31));
      end else begin
        word.year  = YEAR_W'($urandom);
        word.month = MONTH_W'($urandom);
        word.day   = DAY_W'($urandom);
      end
      issue(op, word, 1'b0, '0);
    end
    start <= 1'b0;

    repeat (200) begin
      if (pending_results.size() != 0) begin
        @(posedge clk);
      end
    end
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      note_mismatch("result words never seen, count", 0, pending_results.size());
    end

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
